// ===== rtl/core/gblur_pkg.sv =====
// Shared constants and types for the 3x3 Gaussian blur block.
`default_nettype none
package gblur_pkg;

   // Default geometry limits and coefficient format
   localparam int MAX_WIDTH_DEFAULT      = 1024;
   localparam int MAX_HEIGHT_DEFAULT     = 1024;
   localparam int COEF_FRAC_BITS_DEFAULT = 16;

   // Field widths
   localparam int PIX_W   = 8;
   localparam int DIM_W   = 11;
   localparam int COEF_W  = 16;
   localparam int SIDE_W  = 10;   // sum of four pixels
   localparam int PROD_W  = COEF_W + SIDE_W;
   localparam int ACC_W   = PROD_W + 2;  // sum of three products

   // Input opcodes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // Register map
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CENTER  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_EDGE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CORNER  = 3'd4;

   // Register reset values
   localparam logic [DIM_W-1:0]  IMAGE_WIDTH_RST  = 11'd640;
   localparam logic [DIM_W-1:0]  IMAGE_HEIGHT_RST = 11'd480;
   localparam logic [COEF_W-1:0] COEF_CENTER_RST  = 16'd16299;
   localparam logic [COEF_W-1:0] COEF_EDGE_RST    = 16'd7462;
   localparam logic [COEF_W-1:0] COEF_CORNER_RST  = 16'd3416;

   // Result queue
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = RSP_PTR_W + 1;

   // One queue entry holds all words caused by one input word
   typedef struct packed {
      logic [PIX_W-1:0] first;
      logic [PIX_W-1:0] second;
      logic             two;      // end of row: second word present
      logic             eof;      // second word ends the frame
   } rsp_entry_type;

endpackage
`default_nettype wire

// ===== rtl/core/gaussian_blur_3x3_clamped_top.sv =====
// Top level of the streaming 3x3 Gaussian blur with border clamping.
//  - req_ channel: one word per pixel in raster order (req_opcode = pixel),
//    then image_width drain words (req_opcode = drain) to flush the last row.
//    A word is taken when req_valid is high and req_stall is low.
//  - rsp_ channel: blurred pixels in raster order, one row and one pixel
//    behind the input. The word that ends a row yields two results; the
//    second one carries rsp_last_of_run, and on the last drain word also
//    rsp_end_of_frame.
//  - csr_ channel: register writes (index, data), csr_ready is always high.
//    Write only while the block is idle.
//  - Throughput: one input word per cycle while req_stall is low; results
//    leave at one per cycle while rsp_stall is low. A result passes line
//    buffer read, window/sums, multiply and add/round, then the queue.
//  - The two 8-bit line buffers are single-port-read memories with registered
//    read data; a read that hits the entry written in the same cycle is
//    forwarded. Line buffers are not cleared at reset (no clearing pass).
//  - Reset: counters, window and result queue cleared, registers go to their
//    defaults; the block is ready in the first cycle after reset.
//  - Receiver stall: results pile up in an 8-entry queue; req_stall rises when
//    the queue plus the words in flight would fill it.
`default_nettype none
module gaussian_blur_3x3_clamped_top #(
   parameter int MAX_WIDTH      = gblur_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT     = gblur_pkg::MAX_HEIGHT_DEFAULT,
   parameter int COEF_FRAC_BITS = gblur_pkg::COEF_FRAC_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_opcode,
   input  wire logic [gblur_pkg::PIX_W-1:0]     req_pixel_in,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [gblur_pkg::PIX_W-1:0]          rsp_blurred,
   output logic                                 rsp_last_of_run,
   output logic                                 rsp_end_of_frame,
   // configuration channel
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [gblur_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gblur_pkg::CSR_DAT_W-1:0] csr_wdata
);

   localparam int PW = gblur_pkg::PIX_W;
   localparam int CW = $clog2(MAX_WIDTH);           // column address
   localparam int RW = $clog2(MAX_HEIGHT + 1);      // row counter
   localparam int GW = (CW + 1 > gblur_pkg::DIM_W) ? CW + 1 : gblur_pkg::DIM_W;
   localparam int HW = (RW > gblur_pkg::DIM_W) ? RW : gblur_pkg::DIM_W;
   localparam int SW = gblur_pkg::SIDE_W;
   localparam int KW = gblur_pkg::COEF_W;
   localparam int XW = gblur_pkg::PROD_W;
   localparam int AW = gblur_pkg::ACC_W;
   localparam int QD = gblur_pkg::RSP_DEPTH;
   localparam int QP = gblur_pkg::RSP_PTR_W;
   localparam int QC = gblur_pkg::RSP_CNT_W;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [gblur_pkg::DIM_W-1:0] image_width_ff, image_height_ff;
   logic [KW-1:0]               coef_center_ff, coef_edge_ff, coef_corner_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= gblur_pkg::IMAGE_WIDTH_RST;
         image_height_ff <= gblur_pkg::IMAGE_HEIGHT_RST;
         coef_center_ff  <= gblur_pkg::COEF_CENTER_RST;
         coef_edge_ff    <= gblur_pkg::COEF_EDGE_RST;
         coef_corner_ff  <= gblur_pkg::COEF_CORNER_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gblur_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[gblur_pkg::DIM_W-1:0];
            gblur_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[gblur_pkg::DIM_W-1:0];
            gblur_pkg::CSR_COEF_CENTER:  coef_center_ff  <= csr_wdata[KW-1:0];
            gblur_pkg::CSR_COEF_EDGE:    coef_edge_ff    <= csr_wdata[KW-1:0];
            gblur_pkg::CSR_COEF_CORNER:  coef_corner_ff  <= csr_wdata[KW-1:0];
            default: ;
         endcase
      end
   end

   // Geometry clamped into [2, MAX]
   logic [GW-1:0] w_raw, w_eff;
   logic [HW-1:0] h_raw, h_eff;

   always_comb begin
      w_raw = GW'(image_width_ff);
      h_raw = HW'(image_height_ff);
      if (w_raw < GW'(2))              w_eff = GW'(2);
      else if (w_raw > GW'(MAX_WIDTH)) w_eff = GW'(MAX_WIDTH);
      else                             w_eff = w_raw;
      if (h_raw < HW'(2))               h_eff = HW'(2);
      else if (h_raw > HW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
      else                              h_eff = h_raw;
   end

   // ---------------------------------------------------------------------
   // Accept stage: position counters, line buffer read
   // ---------------------------------------------------------------------
   logic [CW-1:0] col_ff, col_in, drn_ff, drn_in;
   logic [RW-1:0] row_ff, row_in;
   logic          req_take;
   logic          go, wr, emit, eor, eof, drain;
   logic [CW-1:0] addr;
   logic          row_done;

   // stage 1 (memory data valid)
   logic          s1_v_ff;
   logic          s1_wr_ff, s1_emit_ff, s1_eor_ff, s1_eof_ff, s1_col0_ff;
   logic          s1_top2_ff, s1_drain_ff, s1_fwd_ff;
   logic [CW-1:0] s1_addr_ff;
   logic [PW-1:0] s1_px_ff, s1_fwd_above_ff, s1_fwd_two_ff;

   // stage 2 (pixel sums), stage 3 (products)
   logic          s2_v_ff, s2_v_in, s3_v_ff;
   logic          s2_eor_ff, s2_eof_ff, s3_eor_ff, s3_eof_ff;

   // result queue
   logic [QC-1:0] q_cnt_ff, q_cnt_in;
   logic [QC:0]   credit;

   assign req_take = req_valid && !req_stall;
   assign row_done = HW'(row_ff) >= h_eff;

   always_comb begin
      go     = 1'b0;
      wr     = 1'b0;
      emit   = 1'b0;
      eor    = 1'b0;
      eof    = 1'b0;
      drain  = 1'b0;
      addr   = col_ff;
      col_in = col_ff;
      row_in = row_ff;
      drn_in = drn_ff;
      if (req_take) begin
         if (req_opcode == gblur_pkg::OP_PIXEL) begin
            if (!row_done) begin
               go   = 1'b1;
               wr   = 1'b1;
               emit = (row_ff != '0);
               eor  = (GW'(col_ff) + GW'(1)) >= w_eff;
               if (eor) begin
                  col_in = '0;
                  row_in = row_ff + RW'(1);
               end else begin
                  col_in = col_ff + CW'(1);
               end
            end
         end else begin
            if (row_done) begin
               go    = 1'b1;
               drain = 1'b1;
               emit  = 1'b1;
               addr  = drn_ff;
               eor   = (GW'(drn_ff) + GW'(1)) >= w_eff;
               eof   = eor;
               if (eor) begin
                  drn_in = '0;
                  row_in = '0;
                  col_in = '0;
               end else begin
                  drn_in = drn_ff + CW'(1);
               end
            end
         end
      end
   end

   // Line buffers
   logic [PW-1:0] row_above_mem     [MAX_WIDTH];
   logic [PW-1:0] row_two_above_mem [MAX_WIDTH];
   logic [PW-1:0] above_q_ff, two_q_ff;

   logic [PW-1:0] mid, two, top, bot;

   always_comb begin
      mid = s1_fwd_ff ? s1_fwd_above_ff : above_q_ff;
      two = s1_fwd_ff ? s1_fwd_two_ff   : two_q_ff;
      top = (s1_drain_ff || s1_top2_ff) ? two : mid;
      bot = s1_drain_ff ? mid : s1_px_ff;
   end

   always_ff @(posedge clock) begin
      if (go) begin
         above_q_ff <= row_above_mem[addr];
         two_q_ff   <= row_two_above_mem[addr];
      end
      if (s1_v_ff && s1_wr_ff) begin
         row_above_mem[s1_addr_ff]     <= s1_px_ff;
         row_two_above_mem[s1_addr_ff] <= mid;
      end
   end

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (go) begin
         s1_wr_ff        <= wr;
         s1_emit_ff      <= emit;
         s1_eor_ff       <= eor;
         s1_eof_ff       <= eof;
         s1_col0_ff      <= (addr == '0);
         s1_top2_ff      <= (row_ff >= RW'(2));
         s1_drain_ff     <= drain;
         s1_addr_ff      <= addr;
         s1_px_ff        <= req_pixel_in;
         // read at the address that stage 1 writes this cycle sees old data
         s1_fwd_ff       <= s1_v_ff && s1_wr_ff && (s1_addr_ff == addr);
         s1_fwd_above_ff <= s1_px_ff;
         s1_fwd_two_ff   <= mid;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: window update and neighbor sums
   // ---------------------------------------------------------------------
   logic [PW-1:0] win_ff [9];
   logic [PW-1:0] win_in [9];

   always_comb begin
      for (int i = 0; i < 9; i++) win_in[i] = win_ff[i];
      if (s1_v_ff && s1_emit_ff) begin
         if (s1_col0_ff) begin
            // first column: replicate the left border
            for (int i = 0; i < 3; i++) begin
               win_in[i]     = top;
               win_in[3 + i] = mid;
               win_in[6 + i] = bot;
            end
         end else begin
            for (int i = 0; i < 3; i++) begin
               win_in[i * 3]     = win_ff[i * 3 + 1];
               win_in[i * 3 + 1] = win_ff[i * 3 + 2];
            end
            win_in[2] = top;
            win_in[5] = mid;
            win_in[8] = bot;
         end
      end
   end

   assign s2_v_in = s1_v_ff && s1_emit_ff && !s1_col0_ff;

   logic [PW-1:0] s2_ctr_a_ff, s2_ctr_b_ff;
   logic [SW-1:0] s2_side_a_ff, s2_side_b_ff, s2_corn_a_ff, s2_corn_b_ff;

   always_ff @(posedge clock) begin
      if (s2_v_in) begin
         // centered on the middle column
         s2_ctr_a_ff  <= win_in[4];
         s2_side_a_ff <= SW'(win_in[1]) + SW'(win_in[7]) + SW'(win_in[3]) + SW'(win_in[5]);
         s2_corn_a_ff <= SW'(win_in[0]) + SW'(win_in[2]) + SW'(win_in[6]) + SW'(win_in[8]);
         // last pixel of the row: right border replicated
         s2_ctr_b_ff  <= win_in[5];
         s2_side_b_ff <= SW'(win_in[2]) + SW'(win_in[8]) + SW'(win_in[4]) + SW'(win_in[5]);
         s2_corn_b_ff <= SW'(win_in[1]) + SW'(win_in[2]) + SW'(win_in[7]) + SW'(win_in[8]);
         s2_eor_ff    <= s1_eor_ff;
         s2_eof_ff    <= s1_eof_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: products
   // ---------------------------------------------------------------------
   logic [XW-1:0] s3_pc_a_ff, s3_ps_a_ff, s3_pk_a_ff;
   logic [XW-1:0] s3_pc_b_ff, s3_ps_b_ff, s3_pk_b_ff;

   always_ff @(posedge clock) begin
      if (s2_v_ff) begin
         s3_pc_a_ff <= XW'(coef_center_ff) * XW'(s2_ctr_a_ff);
         s3_ps_a_ff <= XW'(coef_edge_ff)   * XW'(s2_side_a_ff);
         s3_pk_a_ff <= XW'(coef_corner_ff) * XW'(s2_corn_a_ff);
         s3_pc_b_ff <= XW'(coef_center_ff) * XW'(s2_ctr_b_ff);
         s3_ps_b_ff <= XW'(coef_edge_ff)   * XW'(s2_side_b_ff);
         s3_pk_b_ff <= XW'(coef_corner_ff) * XW'(s2_corn_b_ff);
         s3_eor_ff  <= s2_eor_ff;
         s3_eof_ff  <= s2_eof_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: sum, round, shift, saturate
   // ---------------------------------------------------------------------
   localparam logic [AW-1:0] ROUND = AW'(1) << (COEF_FRAC_BITS - 1);

   logic [AW-1:0] acc_a, acc_b, shr_a, shr_b;
   logic [PW-1:0] pix_a, pix_b;

   always_comb begin
      acc_a = AW'(s3_pc_a_ff) + AW'(s3_ps_a_ff) + AW'(s3_pk_a_ff) + ROUND;
      acc_b = AW'(s3_pc_b_ff) + AW'(s3_ps_b_ff) + AW'(s3_pk_b_ff) + ROUND;
      shr_a = acc_a >> COEF_FRAC_BITS;
      shr_b = acc_b >> COEF_FRAC_BITS;
      pix_a = (shr_a > AW'(255)) ? '1 : shr_a[PW-1:0];
      pix_b = (shr_b > AW'(255)) ? '1 : shr_b[PW-1:0];
   end

   // ---------------------------------------------------------------------
   // Result queue and output serializer
   // ---------------------------------------------------------------------
   gblur_pkg::rsp_entry_type q_mem_ff [QD];
   gblur_pkg::rsp_entry_type q_head;
   logic [QP-1:0] q_wr_ff, q_rd_ff;
   logic          sel_ff;        // second word of the head entry
   logic          push, pop, rsp_take;

   assign push     = s3_v_ff;
   assign q_head   = q_mem_ff[q_rd_ff];
   assign rsp_take = rsp_valid && !rsp_stall;
   assign pop      = rsp_take && (!q_head.two || sel_ff);
   assign q_cnt_in = q_cnt_ff + QC'(push) - QC'(pop);

   assign rsp_valid        = (q_cnt_ff != '0);
   assign rsp_blurred      = sel_ff ? q_head.second : q_head.first;
   assign rsp_last_of_run  = !q_head.two || sel_ff;
   assign rsp_end_of_frame = sel_ff && q_head.eof;

   // every word in flight may need one queue entry
   assign credit    = (QC + 1)'(q_cnt_ff) + (QC + 1)'(s1_v_ff) + (QC + 1)'(s2_v_ff)
                      + (QC + 1)'(s3_v_ff);
   assign req_stall = credit >= (QC + 1)'(QD);

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[q_wr_ff] <= '{first: pix_a, second: pix_b,
                                two: s3_eor_ff, eof: s3_eof_ff};
      end
   end

   // ---------------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         drn_ff   <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         q_cnt_ff <= '0;
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         sel_ff   <= 1'b0;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         drn_ff   <= drn_in;
         s1_v_ff  <= go;
         s2_v_ff  <= s2_v_in;
         s3_v_ff  <= s2_v_ff;
         q_cnt_ff <= q_cnt_in;
         if (push) q_wr_ff <= q_wr_ff + QP'(1);
         if (pop)  q_rd_ff <= q_rd_ff + QP'(1);
         if (rsp_take) sel_ff <= !pop;
         for (int i = 0; i < 9; i++) win_ff[i] <= win_in[i];
      end
   end

endmodule
`default_nettype wire

// ===== bench/gblur_checker.sv =====
// Checker for the 3x3 Gaussian blur: predicts each blurred word and compares it.
module gblur_checker
   import gblur_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire logic                 req_opcode,
   input  wire logic [PIX_W-1:0]     req_pixel_in,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic [PIX_W-1:0]     rsp_blurred,
   input  wire logic                 rsp_last_of_run,
   input  wire logic                 rsp_end_of_frame,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata,
   output int                        mismatches,
   output int                        pending_pixels
);

   localparam int MAX_W        = MAX_WIDTH_DEFAULT;
   localparam int MAX_H        = MAX_HEIGHT_DEFAULT;
   localparam int FRAC         = COEF_FRAC_BITS_DEFAULT;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [PIX_W-1:0] blurred;
      logic             last_of_run;
      logic             end_of_frame;
   } blur_word_type;

   blur_word_type     expected_pixels[$];
   logic [PIX_W-1:0]  line_above     [MAX_W];
   logic [PIX_W-1:0]  line_two_above [MAX_W];
   logic [PIX_W-1:0]  win [9];            // row*3 + col, col 2 newest
   int unsigned       col_cnt;
   int unsigned       row_cnt;
   int unsigned       drain_cnt;
   logic [DIM_W-1:0]  width_reg;
   logic [DIM_W-1:0]  height_reg;
   logic [COEF_W-1:0] center_reg;
   logic [COEF_W-1:0] edge_reg;
   logic [COEF_W-1:0] corner_reg;

   function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
      if (v < 2) return 2;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // weighted sum around window column m, with l/r as left/right neighbours
   function automatic logic [PIX_W-1:0] blur_at(int l, int m, int r);
      logic [31:0] sides;
      logic [31:0] corners;
      logic [31:0] sum;
      logic [31:0] rounded;
      sides   = 32'(win[m]) + 32'(win[6+m]) + 32'(win[3+l]) + 32'(win[3+r]);
      corners = 32'(win[l]) + 32'(win[r]) + 32'(win[6+l]) + 32'(win[6+r]);
      sum = 32'(center_reg) * 32'(win[3+m]) + 32'(edge_reg) * sides
          + 32'(corner_reg) * corners;
      rounded = (sum + (32'd1 << (FRAC-1))) >> FRAC;
      return (rounded > 32'd255) ? 8'd255 : rounded[PIX_W-1:0];
   endfunction

   function automatic void shift_and_emit(int unsigned c, logic [PIX_W-1:0] top,
                                          logic [PIX_W-1:0] mid, logic [PIX_W-1:0] bot,
                                          bit end_row, bit end_frame);
      blur_word_type entry;
      if (c == 0) begin
         // first column: replicate the border pixel across the window
         for (int i = 0; i < 3; i++) begin
            win[i]   = top;
            win[3+i] = mid;
            win[6+i] = bot;
         end
         return;
      end
      for (int i = 0; i < 3; i++) begin
         win[i*3]   = win[i*3+1];
         win[i*3+1] = win[i*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = bot;
      entry = '{blur_at(0, 1, 2), !end_row, 1'b0};
      expected_pixels.insert(expected_pixels.size(), entry);
      if (end_row) begin
         entry = '{blur_at(1, 2, 2), 1'b1, end_frame};
         expected_pixels.insert(expected_pixels.size(), entry);
      end
   endfunction

   function automatic void predict_word(logic op, logic [PIX_W-1:0] px);
      int unsigned      w;
      int unsigned      h;
      int unsigned      c;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      bit               end_row;
      w = clamp_dim(width_reg, MAX_W);
      h = clamp_dim(height_reg, MAX_H);
      if (op == OP_PIXEL) begin
         if (row_cnt >= h) return;      // frame complete, waiting for drain
         c = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;
         end_row = (c + 1 >= w);
         mid = line_above[c];
         top = (row_cnt >= 2) ? line_two_above[c] : mid;
         line_two_above[c] = mid;
         line_above[c] = px;
         if (row_cnt >= 1)
            shift_and_emit(c, top, mid, px, end_row, 1'b0);
         if (end_row) begin
            col_cnt = 0;
            row_cnt++;
         end else begin
            col_cnt = c + 1;
         end
      end else begin
         if (row_cnt < h) return;       // drain too early
         c = (drain_cnt >= MAX_W) ? MAX_W - 1 : drain_cnt;
         end_row = (c + 1 >= w);
         mid = line_above[c];
         top = line_two_above[c];
         shift_and_emit(c, top, mid, mid, end_row, end_row);
         if (end_row) begin
            drain_cnt = 0;
            row_cnt = 0;
            col_cnt = 0;
         end else begin
            drain_cnt = c + 1;
         end
      end
   endfunction

   always @(posedge clock) begin
      blur_word_type want;
      blur_word_type got;
      if (reset) begin
         expected_pixels.delete();
         foreach (line_above[i]) line_above[i] = '0;
         foreach (line_two_above[i]) line_two_above[i] = '0;
         foreach (win[i]) win[i] = '0;
         col_cnt    = 0;
         row_cnt    = 0;
         drain_cnt  = 0;
         width_reg  = IMAGE_WIDTH_RST;
         height_reg = IMAGE_HEIGHT_RST;
         center_reg = COEF_CENTER_RST;
         edge_reg   = COEF_EDGE_RST;
         corner_reg = COEF_CORNER_RST;
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_blurred, rsp_last_of_run, rsp_end_of_frame};
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("ERROR: unexpected result word blurred=%0d last=%0b eof=%0b",
                           got.blurred, got.last_of_run, got.end_of_frame);
            end else begin
               want = expected_pixels.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("ERROR: exp blurred=%0d last=%0b eof=%0b, got %0d %0b %0b",
                              want.blurred, want.last_of_run, want.end_of_frame,
                              got.blurred, got.last_of_run, got.end_of_frame);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_reg  = csr_wdata[DIM_W-1:0];
               CSR_IMAGE_HEIGHT: height_reg = csr_wdata[DIM_W-1:0];
               CSR_COEF_CENTER:  center_reg = csr_wdata[COEF_W-1:0];
               CSR_COEF_EDGE:    edge_reg   = csr_wdata[COEF_W-1:0];
               CSR_COEF_CORNER:  corner_reg = csr_wdata[COEF_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_word(req_opcode, req_pixel_in);
      end
      pending_pixels = expected_pixels.size();
   end

endmodule

// ===== bench/gaussian_blur_3x3_clamped_top_tb.sv =====
// Top of the Gaussian blur testbench: clock, reset, stimulus and verdict.
module gaussian_blur_3x3_clamped_top_tb;
   import gblur_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
   localparam int SETTLE_CYCLES = 12;      // drains the pipe plus margin
   localparam int TOTAL_WORDS   = 1300;
   localparam int HOLD_CYCLES   = 300;
   // indexes past the register map; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_COEF_CORNER + 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = '1;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_opcode;
   logic [PIX_W-1:0]     req_pixel_in;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [PIX_W-1:0]     rsp_blurred;
   logic                 rsp_last_of_run;
   logic                 rsp_end_of_frame;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   int mismatches;
   int pending_pixels;
   int cycle_count    = 0;
   int send_idle_pct  = 0;   // chance the sender skips a cycle
   int recv_stall_pct = 0;   // chance the receiver stalls a cycle
   int hold_len       = 0;
   logic hold_req     = 1'b0;
   logic hold_active  = 1'b0;

   gaussian_blur_3x3_clamped_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_pixel_in     (req_pixel_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_blurred      (rsp_blurred),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   gblur_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_pixel_in     (req_pixel_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_blurred      (rsp_blurred),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .pending_pixels   (pending_pixels)
   );

   // 8-unit clock, high half first
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // watchdog: a hung block or a lost result ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // long receiver hold-off, counted here so the stimulus keeps offering words
   always begin
      wait (hold_req);
      hold_active = 1'b1;
      repeat (hold_len) @(posedge clock);
      hold_active = 1'b0;
      hold_req    = 1'b0;
   end

   // receiver: random stall per cycle, forced high during a hold-off
   always @(negedge clock)
      rsp_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);

   // Clamp a written dimension the same way the block does, so the
   // stimulus knows how many words make up a frame.
   function automatic int unsigned frame_dim(logic [CSR_DAT_W-1:0] raw, int unsigned maxv);
      logic [DIM_W-1:0] v;
      v = raw[DIM_W-1:0];
      if (v < 2) return 2;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // Coefficients: half full-range random, some limited to 0..20000 like a real
   // kernel's, some at the extremes.
   function automatic logic [COEF_W-1:0] pick_coef();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 50) return COEF_W'($urandom_range(0, 65535));
      if (sel < 80) return COEF_W'($urandom_range(0, 20000));
      return $urandom_range(1) ? '1 : '0;
   endfunction

   // One input word; valid stays high from one word to the next unless a
   // gap is taken, so it is never lowered and raised in the same step.
   task automatic send_word(logic op, logic [PIX_W-1:0] px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_pixel_in <= px;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Wait until every predicted word has come out, then let the pipe empty
   // of words that cause no result.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_pixels != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_frame(logic [CSR_DAT_W-1:0] w_word, logic [CSR_DAT_W-1:0] h_word,
                            logic [COEF_W-1:0] cc, logic [COEF_W-1:0] ce,
                            logic [COEF_W-1:0] ck);
      settle();
      csr_write(CSR_IMAGE_WIDTH, w_word);
      csr_write(CSR_IMAGE_HEIGHT, h_word);
      csr_write(CSR_COEF_CENTER, cc);
      csr_write(CSR_COEF_EDGE, ce);
      csr_write(CSR_COEF_CORNER, ck);
      csr_write(CSR_IDX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)),
                CSR_DAT_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Full frame: w*h pixels then w drain words. With noise, ignored words
   // are mixed in: early drains inside the frame, stray pixels after the
   // last row.
   task automatic send_frame(int unsigned w, int unsigned h, bit noisy, inout int words);
      for (int unsigned r = 0; r < h; r++) begin
         for (int unsigned c = 0; c < w; c++) begin
            if (noisy && $urandom_range(99) < 4)
               send_word(OP_DRAIN, PIX_W'($urandom));
            send_word(OP_PIXEL, PIX_W'($urandom));
         end
      end
      if (noisy && $urandom_range(99) < 30)
         repeat ($urandom_range(1, 3)) send_word(OP_PIXEL, PIX_W'($urandom));
      for (int unsigned c = 0; c < w; c++)
         send_word(OP_DRAIN, PIX_W'($urandom));
      words += w * h + w;
   endtask

   initial begin
      int                   words;
      int                   frame_no;
      int unsigned          sel;
      logic [DIM_W-1:0]     raw_w;
      logic [DIM_W-1:0]     raw_h;
      logic [CSR_DAT_W-1:0] w_word;
      logic [CSR_DAT_W-1:0] h_word;

      // every input known from time zero
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_opcode   = OP_PIXEL;
      req_pixel_in = '0;
      rsp_stall    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = CSR_IMAGE_WIDTH;
      csr_wdata    = '0;
      words        = 0;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed ---------------------------------------------------
      // 3x2 frame on the reset coefficients: only geometry is written.
      csr_write(CSR_IMAGE_WIDTH, 16'd3);
      csr_write(CSR_IMAGE_HEIGHT, 16'd2);
      csr_valid <= 1'b0;
      send_word(OP_DRAIN, 8'h5A);            // drain before any row: ignored
      send_word(OP_PIXEL, 8'd0);
      send_word(OP_PIXEL, 8'd255);
      send_word(OP_PIXEL, 8'd17);
      send_word(OP_PIXEL, 8'd255);
      send_word(OP_PIXEL, 8'd0);
      send_word(OP_PIXEL, 8'd128);
      send_word(OP_PIXEL, 8'd99);            // pixel after last row: ignored
      send_word(OP_DRAIN, 8'hFF);
      send_word(OP_DRAIN, 8'h00);
      send_word(OP_DRAIN, 8'hA5);

      // width 0 and height 1 both clamp to 2; full-scale weights saturate
      set_frame(16'd0, 16'd1, '1, '1, '1);
      send_word(OP_PIXEL, 8'd255);
      send_word(OP_PIXEL, 8'd255);
      send_word(OP_PIXEL, 8'd255);
      send_word(OP_PIXEL, 8'd1);
      send_word(OP_DRAIN, 8'd0);
      send_word(OP_DRAIN, 8'd0);

      // upper data bits above the 11-bit width are dropped: width 2;
      // zero weights give zero everywhere
      set_frame(16'hF802, 16'd2, '0, '0, '0);
      send_word(OP_PIXEL, 8'd200);
      send_word(OP_PIXEL, 8'd1);
      send_word(OP_PIXEL, 8'd2);
      send_word(OP_PIXEL, 8'd3);
      send_word(OP_DRAIN, 8'd0);
      send_word(OP_DRAIN, 8'd0);

      // --- wide frame, no idling ----------------------------------------
      words = 0;
      set_frame(16'd128, 16'd2, pick_coef(), pick_coef(), pick_coef());
      send_frame(128, 2, 1'b0, words);

      // --- back-pressure: receiver holds off while the sender streams ---
      set_frame(16'd16, 16'd6, pick_coef(), pick_coef(), pick_coef());
      hold_len <= HOLD_CYCLES;
      hold_req <= 1'b1;
      send_frame(16, 6, 1'b0, words);

      // --- random frames, rotating through the idling phases -----------
      frame_no = 0;
      while (words < TOTAL_WORDS) begin
         settle();
         case ((frame_no / 3) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         sel = $urandom_range(99);
         if (sel < 5)       raw_w = DIM_W'($urandom_range(0, 1));
         else if (sel < 85) raw_w = DIM_W'($urandom_range(2, 12));
         else               raw_w = DIM_W'($urandom_range(13, 40));
         raw_h = ($urandom_range(99) < 5) ? DIM_W'($urandom_range(0, 1))
                                          : DIM_W'($urandom_range(2, 6));
         // random junk in the bits above the dimension field
         w_word = {(CSR_DAT_W-DIM_W)'($urandom), raw_w};
         h_word = {(CSR_DAT_W-DIM_W)'($urandom), raw_h};
         set_frame(w_word, h_word, pick_coef(), pick_coef(), pick_coef());
         send_frame(frame_dim(w_word, MAX_WIDTH_DEFAULT),
                    frame_dim(h_word, MAX_HEIGHT_DEFAULT), 1'b1, words);
         frame_no++;
      end

      settle();
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
